// ===== src/iss_pkg.sv =====
// Shared constants, codes and types for the integer store sorter.
`timescale 1ns / 1ps
`default_nettype none
package iss_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_SORT   = 2'd1,
    FUNC_READ   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_RANGE = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_WAIT,
    ST_SORT_KEY,
    ST_SORT_CMP,
    ST_SORT_PLACE
  } state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

endpackage
`default_nettype wire

// ===== src/iss_ram.sv =====
// Value store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module iss_ram (
  input  wire                        clk,
  input  wire iss_pkg::mem_wr_t      wr,
  input  wire [iss_pkg::ADDR_W-1:0]  raddr,
  output logic [iss_pkg::DATA_W-1:0] rdata
);
  import iss_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/integer_store_sorter.sv =====
// Integer store sorter top level: controller, result register and value store.
// Append, out-of-range read, unused codes: result in the next cycle, one per cycle if out_ready.
// Read in range: store read in ST_READ_WAIT, then result register; no new request meanwhile.
// Sort: insertion sort through the single read port; ST_SORT_KEY loads each key, ST_SORT_CMP
// does each compare, ST_SORT_PLACE puts a key at entry zero; input stalls until done.
// Synchronous reset empties the store (fill zero); entry contents and count are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module integer_store_sorter (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [1:0]                        func,
  input  wire  signed [iss_pkg::DATA_W-1:0] value,
  input  wire  [iss_pkg::ADDR_W-1:0]        index,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic signed [iss_pkg::DATA_W-1:0] data,
  output logic [iss_pkg::CNT_W-1:0]         count,
  output logic [1:0]                        error
);
  import iss_pkg::*;

  state_t            state, state_next;
  logic [CNT_W-1:0]  fill, fill_next;
  logic [ADDR_W-1:0] i, i_next;
  logic [ADDR_W-1:0] j, j_next;
  logic [DATA_W-1:0] key, key_next;
  logic              out_valid_next;

  logic              load;
  logic [DATA_W-1:0] res_data;
  err_t              res_err;
  logic              last_key;

  mem_wr_t           wr;
  logic [ADDR_W-1:0] raddr;
  logic [DATA_W-1:0] rdata;

  iss_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign last_key = ({1'b0, i} == (fill - CNT_W'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    i   <= i_next;
    j   <= j_next;
    key <= key_next;
    if (load) begin
      data  <= res_data;
      count <= fill_next;
      error <= res_err;
    end
  end

  always_comb begin
    state_next = state;
    fill_next  = fill;
    i_next     = i;
    j_next     = j;
    key_next   = key;
    load       = 1'b0;
    res_data   = '0;
    res_err    = ERR_OK;
    wr         = '0;
    raddr      = index;

    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          case (func)
            FUNC_APPEND: begin
              load = 1'b1;
              if (fill == FULL_CNT) begin
                res_err = ERR_FULL;
              end else begin
                wr.en     = 1'b1;
                wr.addr   = fill[ADDR_W-1:0];
                wr.data   = value;
                fill_next = fill + CNT_W'(1);
              end
            end
            FUNC_SORT: begin
              if (fill < CNT_W'(2)) begin
                load = 1'b1;
              end else begin
                i_next     = ADDR_W'(1);
                raddr      = ADDR_W'(1);
                state_next = ST_SORT_KEY;
              end
            end
            FUNC_READ: begin
              if ({1'b0, index} < fill) begin
                raddr      = index;
                state_next = ST_READ_WAIT;
              end else begin
                res_err = ERR_RANGE;
                load    = 1'b1;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_READ_WAIT: begin
        res_data   = rdata;
        load       = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SORT_KEY: begin
        key_next   = rdata;
        j_next     = i;
        raddr      = i - ADDR_W'(1);
        state_next = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        wr.en   = 1'b1;
        wr.addr = j;
        if ($signed(key) < $signed(rdata)) begin
          // shift the larger entry up one place
          wr.data = rdata;
          j_next  = j - ADDR_W'(1);
          if (j == ADDR_W'(1)) begin
            state_next = ST_SORT_PLACE;
          end else begin
            raddr = j - ADDR_W'(2);
          end
        end else begin
          wr.data = key;
          if (last_key) begin
            load       = 1'b1;
            state_next = ST_IDLE;
          end else begin
            i_next     = i + ADDR_W'(1);
            raddr      = i + ADDR_W'(1);
            state_next = ST_SORT_KEY;
          end
        end
      end
      ST_SORT_PLACE: begin
        wr.en   = 1'b1;
        wr.addr = '0;
        wr.data = key;
        if (last_key) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end else begin
          i_next     = i + ADDR_W'(1);
          raddr      = i + ADDR_W'(1);
          state_next = ST_SORT_KEY;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule
`default_nettype wire
